### rtl/core/scd_pkg.sv
// Shared types, constants and the CRC-8 byte update for the scratchpad CRC decoder.
// No dependencies.
package scd_pkg;

  // Reflected form of polynomial 0x31, shifted right, LSB first
  localparam logic [7:0] CrcPolyRefl = 8'h8C;
  localparam logic [7:0] CrcInit     = 8'h00;

  // One result word handed from the CRC core to the output register
  typedef struct packed {
    logic signed [15:0] temperature_sixteenths;
    logic               crc_ok;
  } result_t;

  // Eight unrolled reflected CRC steps over one data byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    logic       fb;
    crc = crc_in;
    for (int k = 0; k < 8; k++) begin
      fb  = crc[0] ^ data[k];
      crc = {1'b0, crc[7:1]};
      if (fb) begin
        crc = crc ^ CrcPolyRefl;
      end
    end
    return crc;
  endfunction

endpackage

### rtl/core/scd_byte_if.sv
// Valid/ready channel carrying one scratchpad byte per word.
// No dependencies.
interface scd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

### rtl/core/scd_result_if.sv
// Valid/ready channel carrying one decoded reading per word.
// No dependencies.
interface scd_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature_sixteenths;
  logic               crc_ok;

  modport source (output valid, output temperature_sixteenths, output crc_ok, input ready);
  modport sink   (input valid, input temperature_sixteenths, input crc_ok, output ready);
endinterface

### rtl/core/scd_in_reg.sv
// Input register stage: captures one byte word and holds it until the core consumes it.
// No package dependencies.
module scd_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_data_i,
  input  logic       advance_i,
  output logic       ready_o,
  output logic       valid_o,
  output logic [7:0] data_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       load;

  // Free when empty or when the held word moves on this cycle
  assign ready_o = !valid_q || advance_i;
  assign load    = in_valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### rtl/core/scd_crc_core.sv
// CRC-8 accumulator, byte position tracking and reading selection.
// Depends on scd_pkg (crc8_byte, result_t).
module scd_crc_core #(
  parameter int BYTES_PER_READING = 9
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          data_i,
  input  logic                advance_i,
  output logic                last_o,
  output scd_pkg::result_t    res_o
);

  localparam int IdxW    = $clog2(BYTES_PER_READING);
  localparam int LastIdx = BYTES_PER_READING - 1;

  logic [7:0]      crc_q, crc_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      low_q, low_d;
  logic [7:0]      high_q, high_d;
  logic [15:0]     good_q, good_d;
  logic [7:0]      crc_next;
  logic            crc_ok;

  assign crc_next = scd_pkg::crc8_byte(crc_q, data_i);
  assign crc_ok   = (crc_next == 8'h00);
  assign last_o   = (idx_q >= IdxW'(LastIdx));

  // Result for the last byte of a reading
  always_comb begin
    res_o.crc_ok                 = crc_ok;
    res_o.temperature_sixteenths = crc_ok ? $signed({high_q, low_q}) : $signed(good_q);
  end

  // State update on every consumed byte
  always_comb begin
    crc_d  = crc_q;
    idx_d  = idx_q;
    low_d  = low_q;
    high_d = high_q;
    good_d = good_q;
    if (advance_i) begin
      if (idx_q == IdxW'(0)) begin
        low_d = data_i;
      end else if (idx_q == IdxW'(1)) begin
        high_d = data_i;
      end
      if (last_o) begin
        crc_d = scd_pkg::CrcInit;
        idx_d = '0;
        if (crc_ok) begin
          good_d = {high_q, low_q};
        end
      end else begin
        crc_d = crc_next;
        idx_d = idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= scd_pkg::CrcInit;
      idx_q  <= '0;
      low_q  <= '0;
      high_q <= '0;
      good_q <= '0;
    end else begin
      crc_q  <= crc_d;
      idx_q  <= idx_d;
      low_q  <= low_d;
      high_q <= high_d;
      good_q <= good_d;
    end
  end

endmodule

### rtl/core/sensor_scratchpad_crc_decoder.sv
// Scratchpad CRC decoder: one byte word per cycle, one reading word per BYTES_PER_READING bytes.
// Path: input register, combinational unrolled CRC-8, then result register for the last byte.
// Throughput: 1 byte per cycle unless the last byte of a reading waits for the result register.
// Reset: asynchronous, active low; clears CRC, byte position, held bytes and last good reading.
// Depends on scd_pkg, scd_byte_if, scd_result_if, scd_in_reg, scd_crc_core.
module sensor_scratchpad_crc_decoder #(
  parameter int BYTES_PER_READING = 9
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  scd_byte_if.sink            byte_i,
  scd_result_if.source        result_o
);

  logic             s_valid;
  logic [7:0]       s_data;
  logic             s_last;
  logic             advance;
  logic             out_free;
  scd_pkg::result_t core_res;

  logic             out_valid_q, out_valid_d;
  scd_pkg::result_t out_q;

  // Input register
  scd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (byte_i.valid),
    .in_data_i  (byte_i.data_byte),
    .advance_i  (advance),
    .ready_o    (byte_i.ready),
    .valid_o    (s_valid),
    .data_o     (s_data)
  );

  // CRC and reading logic
  scd_crc_core #(
    .BYTES_PER_READING (BYTES_PER_READING)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .data_i    (s_data),
    .advance_i (advance),
    .last_o    (s_last),
    .res_o     (core_res)
  );

  // Intermediate bytes retire freely; the last byte needs room in the result register
  assign out_free = !out_valid_q || result_o.ready;
  assign advance  = s_valid && (!s_last || out_free);

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && s_last) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s_last) begin
      out_q <= core_res;
    end
  end

  assign result_o.valid                  = out_valid_q;
  assign result_o.temperature_sixteenths = out_q.temperature_sixteenths;
  assign result_o.crc_ok                 = out_q.crc_ok;

endmodule
